>>> sv/silu_pkg.sv
// silu_pkg: shared constants, command and status codes, and types for the
// sorted insertion list unit. No dependencies.
package silu_pkg;

  localparam int CAPACITY = 16;
  localparam int KEY_BITS = 7;
  localparam int TAG_BITS = 16;
  localparam int CMD_BITS = 2;
  localparam int POS_BITS = 4;
  localparam int STATUS_BITS = 2;

  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CMP_BITS = (CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS;

  localparam int IN_W = CMD_BITS + KEY_BITS + TAG_BITS + POS_BITS;
  localparam int IN_DATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W = STATUS_BITS + KEY_BITS + TAG_BITS + CNT_BITS;
  localparam int OUT_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SPARE = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } entry_t;

  // per-cell control, built by the top level for each position
  typedef struct packed {
    logic insert;    // accepted insert into a list that has room
    logic remove;    // accepted remove at a valid position
    logic occupied;  // cell index below entry count
    logic past_pos;  // cell index at or after the remove position
  } cell_ctl_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic [TAG_BITS-1:0] entry_tag;
    logic [KEY_BITS-1:0] entry_key;
    logic [CMD_BITS-1:0] cmd;
  } in_beat_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]    entry_count;
    logic [TAG_BITS-1:0]    read_tag;
    logic [KEY_BITS-1:0]    read_key;
    logic [STATUS_BITS-1:0] status;
  } out_beat_t;

endpackage

>>> sv/sorted_insertion_list_unit.sv
// sorted_insertion_list_unit: key-ordered list built as a row of silu_cell
// instances with a registered result beat. Depends on silu_pkg, silu_cell.
// The result beat is registered and appears in the cycle after the command beat is taken.
// Throughput: one command per cycle while m_tready holds; every cell updates in the same cycle.
// The output register is refilled in the cycle its beat is taken.
// Reset (rst, synchronous): entry count zero, no result pending.
module sorted_insertion_list_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // cmd, entry_key, entry_tag, position
  input  logic [silu_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // status, read_key, read_tag, entry_count
  output logic [silu_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int N = silu_pkg::CAPACITY;

  silu_pkg::in_beat_t  in_beat;
  silu_pkg::out_beat_t res;
  silu_pkg::out_beat_t res_next;
  silu_pkg::entry_t    new_entry;
  silu_pkg::entry_t    cells [N];
  silu_pkg::cell_ctl_t ctl [N];
  logic [N-1:0]        gt;
  logic [silu_pkg::CNT_BITS-1:0] count;
  logic [silu_pkg::CNT_BITS-1:0] count_next;
  logic [silu_pkg::CMP_BITS-1:0] pos_ext;
  logic [silu_pkg::CMP_BITS-1:0] count_ext;
  logic [silu_pkg::IDX_BITS-1:0] rd_idx;
  logic fire, full, pos_ok, ins_ok, rem_ok;

  assign in_beat   = silu_pkg::in_beat_t'(s_tdata[silu_pkg::IN_W-1:0]);
  assign new_entry = '{key: in_beat.entry_key, tag: in_beat.entry_tag};
  assign s_tready  = !m_tvalid || m_tready;
  assign fire      = s_tvalid && s_tready;
  assign full      = (count == silu_pkg::CNT_BITS'(N));
  assign pos_ext   = silu_pkg::CMP_BITS'(in_beat.position);
  assign count_ext = silu_pkg::CMP_BITS'(count);
  assign pos_ok    = pos_ext < count_ext;
  assign rd_idx    = silu_pkg::IDX_BITS'(in_beat.position);
  assign ins_ok    = fire && (in_beat.cmd == silu_pkg::CMD_INSERT) && !full;
  assign rem_ok    = fire && (in_beat.cmd == silu_pkg::CMD_REMOVE) && pos_ok;

  for (genvar i = 0; i < N; i++) begin : g_cell
    silu_pkg::entry_t prev_e;
    silu_pkg::entry_t next_e;
    logic             prev_g;

    assign ctl[i].insert   = ins_ok;
    assign ctl[i].remove   = rem_ok;
    assign ctl[i].occupied = silu_pkg::CMP_BITS'(i) < count_ext;
    assign ctl[i].past_pos = silu_pkg::CMP_BITS'(i) >= pos_ext;

    if (i == 0) begin : g_first
      assign prev_e = new_entry;
      assign prev_g = 1'b0;
    end else begin : g_mid
      assign prev_e = cells[i-1];
      assign prev_g = gt[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_e = cells[i];
    end else begin : g_inner
      assign next_e = cells[i+1];
    end

    silu_cell u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .prev_gt    (prev_g),
      .next_entry (next_e),
      .entry      (cells[i]),
      .gt         (gt[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ins_ok) begin
      count_next = count + silu_pkg::CNT_BITS'(1);
    end else if (rem_ok) begin
      count_next = count - silu_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    res_next             = '0;
    res_next.status      = silu_pkg::ST_DONE;
    res_next.entry_count = count_next;
    case (in_beat.cmd)
      silu_pkg::CMD_INSERT: begin
        if (full) begin
          res_next.status = silu_pkg::ST_FULL;
        end
      end
      silu_pkg::CMD_REMOVE: begin
        if (!pos_ok) begin
          res_next.status = silu_pkg::ST_RANGE;
        end
      end
      silu_pkg::CMD_READ: begin
        if (pos_ok) begin
          res_next.read_key = cells[rd_idx].key;
          res_next.read_tag = cells[rd_idx].tag;
        end else begin
          res_next.status = silu_pkg::ST_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign m_tdata = silu_pkg::OUT_DATA_W'(res);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= silu_pkg::CNT_BITS'(N))
    else $error("entry count above capacity");

  a_full_flag: assert property (@(posedge clk) disable iff (rst)
    fire && (in_beat.cmd == silu_pkg::CMD_INSERT) && full |=>
      res.status == silu_pkg::ST_FULL && $stable(count))
    else $error("insert into full list not flagged");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(count))
    else $error("entry count changed without a beat");

  a_result_pending: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid && res.entry_count == count)
    else $error("result beat missing after command");

endmodule

>>> sv/silu_cell.sv
// silu_cell: one position of the sorted list; holds an entry and shifts it
// toward either neighbor on insert or remove. Depends on silu_pkg.
module silu_cell (
  input  logic                clk,
  input  silu_pkg::cell_ctl_t ctl,
  input  silu_pkg::entry_t    new_entry,
  input  silu_pkg::entry_t    prev_entry,
  input  logic                prev_gt,
  input  silu_pkg::entry_t    next_entry,
  output silu_pkg::entry_t    entry,
  output logic                gt
);

  // an empty cell counts as greater, so the insert slot is the first such cell
  assign gt = !ctl.occupied || (new_entry.key < entry.key);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      if (prev_gt) begin
        entry <= prev_entry;
      end else if (gt) begin
        entry <= new_entry;
      end
    end else if (ctl.remove && ctl.past_pos) begin
      entry <= next_entry;
    end
  end

endmodule
